// File: sv/tpq_pkg.sv
// Package for the touch press qualifier: beat structs, register indexes,
// result codes and timing constants. No dependencies.
`default_nettype none

package tpq_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_COUNT      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_COUNT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STABILITY_PIXELS = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REPRESS_GAP_MS   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BOOT_MUTE_MS     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FAIL_LIMIT       = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_START_ONLINE     = 3'd6;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OFFLINE = 2'd1;
  localparam logic [1:0] ST_FAIL    = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  localparam logic [8:0]  SCREEN_W         = 9'd480;
  localparam logic [8:0]  SCREEN_H         = 9'd320;
  localparam logic [31:0] REPROBE_MS       = 32'd10000;
  localparam logic [31:0] CAMERA_BYPASS_MS = 32'd5000;
  localparam logic [31:0] RECOVER_COOL_MS  = 32'd2000;
  localparam logic [31:0] BACKOFF_MS       = 32'd100;
  localparam logic [31:0] CACHE_HELD_MS    = 32'd10;
  localparam logic [31:0] CACHE_IDLE_MS    = 32'd15;
  localparam logic [3:0]  COUNT_MAX        = 4'd15;
  localparam logic [3:0]  TOUCH_MASK       = 4'hF;

  typedef struct packed {
    logic [31:0] time_ms;
    logic        read_ok;
    logic        read_timeout;
    logic        servo_busy;
    logic        camera_busy;
    logic        probe_ack;
    logic [7:0]  status_byte;
    logic [7:0]  x_high;
    logic [7:0]  x_low;
    logic [7:0]  y_high;
    logic [7:0]  y_low;
  } tpq_in_t;

  typedef struct packed {
    logic       pressed;
    logic [8:0] x_pos;
    logic [8:0] y_pos;
    logic [1:0] result_status;
    logic       recover_request;
    logic       from_cache;
  } tpq_out_t;

  typedef struct packed {
    logic [3:0]  press_count;
    logic [3:0]  release_count;
    logic [8:0]  stability_pixels;
    logic [15:0] repress_gap_ms;
    logic [15:0] boot_mute_ms;
    logic [3:0]  fail_limit;
    logic        start_online;
  } tpq_cfg_t;

  typedef struct packed {
    logic       touch_hit;
    logic [8:0] nx;
    logic [8:0] ny;
  } tpq_coord_t;

endpackage

`default_nettype wire

// File: sv/tpq_coord.sv
// Coordinate decode: touch count check, rotation and clamping to 480x320.
// Depends on tpq_pkg.
`default_nettype none

module tpq_coord (
  input  tpq_pkg::tpq_in_t    beat,
  output tpq_pkg::tpq_coord_t coord
);
  import tpq_pkg::*;

  logic [3:0]  touches;
  logic [11:0] raw_x;
  logic [11:0] raw_y;
  logic        touch_ok;
  logic [8:0]  nx;
  logic [8:0]  ny;

  always_comb begin
    touches  = beat.status_byte[3:0] & TOUCH_MASK;
    raw_x    = {beat.x_high[3:0], beat.x_low};
    raw_y    = {beat.y_high[3:0], beat.y_low};
    touch_ok = (touches == 4'd1) || (touches == 4'd2);
    nx = '0;
    ny = '0;
    if (touch_ok) begin
      nx = (raw_y > {3'b000, SCREEN_W}) ? SCREEN_W : raw_y[8:0];
      ny = (raw_x > {3'b000, SCREEN_H}) ? SCREEN_H : SCREEN_H - raw_x[8:0];
    end
    coord.nx        = nx;
    coord.ny        = ny;
    coord.touch_hit = touch_ok && !((nx == 9'd0) && (ny == 9'd0));
  end

endmodule

`default_nettype wire

// File: sv/tpq_qualify.sv
// Qualifier state and per-beat decision: online tracking, backoff, cache,
// camera skip, boot mute, debounce and recovery. Depends on tpq_pkg.
`default_nettype none

module tpq_qualify (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  tpq_pkg::tpq_in_t    beat,
  input  tpq_pkg::tpq_coord_t coord,
  input  tpq_pkg::tpq_cfg_t   cfg,
  input  logic                online_load,
  output tpq_pkg::tpq_out_t   res
);
  import tpq_pkg::*;

  logic        online, online_next;
  logic        held, held_next;
  logic [31:0] reprobe_time, reprobe_time_next;
  logic [31:0] fail_time, fail_time_next;
  logic [31:0] sample_time, sample_time_next;
  logic [31:0] release_time, release_time_next;
  logic [31:0] camera_skip_start, camera_skip_start_next;
  logic [31:0] recover_time, recover_time_next;
  logic [31:0] mute_start, mute_start_next;
  logic [8:0]  held_x, held_x_next;
  logic [8:0]  held_y, held_y_next;
  logic [8:0]  run_x, run_x_next;
  logic [8:0]  run_y, run_y_next;
  logic [3:0]  fail_count, fail_count_next;
  logic [3:0]  press_run, press_run_next;
  logic [3:0]  miss_run, miss_run_next;

  function automatic logic [3:0] sat_inc(input logic [3:0] v);
    return (v < COUNT_MAX) ? v + 4'd1 : COUNT_MAX;
  endfunction

  function automatic logic [8:0] abs_diff(input logic [8:0] a, input logic [8:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      online            <= 1'b1;
      held              <= 1'b0;
      reprobe_time      <= '0;
      fail_time         <= '0;
      sample_time       <= '0;
      release_time      <= '0;
      camera_skip_start <= '0;
      recover_time      <= '0;
      mute_start        <= '0;
      held_x            <= '0;
      held_y            <= '0;
      run_x             <= '0;
      run_y             <= '0;
      fail_count        <= '0;
      press_run         <= '0;
      miss_run          <= '0;
    end else if (online_load) begin
      online <= cfg.start_online;
    end else if (go) begin
      online            <= online_next;
      held              <= held_next;
      reprobe_time      <= reprobe_time_next;
      fail_time         <= fail_time_next;
      sample_time       <= sample_time_next;
      release_time      <= release_time_next;
      camera_skip_start <= camera_skip_start_next;
      recover_time      <= recover_time_next;
      mute_start        <= mute_start_next;
      held_x            <= held_x_next;
      held_y            <= held_y_next;
      run_x             <= run_x_next;
      run_y             <= run_y_next;
      fail_count        <= fail_count_next;
      press_run         <= press_run_next;
      miss_run          <= miss_run_next;
    end
  end

  always_comb begin
    logic [31:0] now;
    logic [31:0] now_nz;
    logic [31:0] cam_eff;
    logic [31:0] mute_eff;
    logic [31:0] cache_lim;
    logic        rp;
    logic [3:0]  fc;
    logic [3:0]  pr;
    logic [3:0]  mr;
    logic [8:0]  hx;
    logic [8:0]  hy;

    now       = beat.time_ms;
    now_nz    = (now == 32'd0) ? 32'd1 : now;
    cache_lim = held ? CACHE_HELD_MS : CACHE_IDLE_MS;
    cam_eff   = camera_skip_start;
    mute_eff  = mute_start;
    rp        = 1'b0;
    fc        = fail_count;
    pr        = press_run;
    mr        = miss_run;
    hx        = held_x;
    hy        = held_y;

    online_next            = online;
    held_next              = held;
    reprobe_time_next      = reprobe_time;
    fail_time_next         = fail_time;
    sample_time_next       = sample_time;
    release_time_next      = release_time;
    camera_skip_start_next = camera_skip_start;
    recover_time_next      = recover_time;
    mute_start_next        = mute_start;
    held_x_next            = held_x;
    held_y_next            = held_y;
    run_x_next             = run_x;
    run_y_next             = run_y;
    fail_count_next        = fail_count;
    press_run_next         = press_run;
    miss_run_next          = miss_run;
    res                    = '0;

    if (!online) begin
      if (now - reprobe_time >= REPROBE_MS) begin
        reprobe_time_next = now;
        if (beat.probe_ack) begin
          online_next = 1'b1;
        end
      end
      res.result_status = ST_OFFLINE;
    end else if ((fail_time != 32'd0) && (now - fail_time < BACKOFF_MS)) begin
      res.result_status = ST_FAIL;
    end else if (now - sample_time < cache_lim) begin
      res.pressed    = held;
      res.x_pos      = held ? held_x : 9'd0;
      res.y_pos      = held ? held_y : 9'd0;
      res.from_cache = 1'b1;
    end else begin
      if (beat.camera_busy) begin
        if (camera_skip_start == 32'd0) begin
          cam_eff = now_nz;
        end
        camera_skip_start_next = cam_eff;
      end else begin
        camera_skip_start_next = '0;
      end
      if (beat.camera_busy && (now - cam_eff < CAMERA_BYPASS_MS)) begin
        res.pressed    = held;
        res.x_pos      = held ? held_x : 9'd0;
        res.y_pos      = held ? held_y : 9'd0;
        res.from_cache = 1'b1;
      end else begin
        sample_time_next = now;
        if (!beat.read_ok) begin
          fail_time_next = now_nz;
          if (beat.read_timeout) begin
            res.result_status = ST_TIMEOUT;
          end else if (beat.servo_busy) begin
            res.result_status = ST_FAIL;
          end else begin
            fc                = sat_inc(fail_count);
            fail_count_next   = fc;
            res.result_status = ST_FAIL;
            if ((fc >= cfg.fail_limit) && (now - recover_time > RECOVER_COOL_MS)) begin
              res.recover_request = 1'b1;
              recover_time_next   = now;
              fail_count_next     = '0;
              online_next         = beat.probe_ack;
              mute_start_next     = '0;
            end
          end
        end else begin
          fail_count_next = '0;
          fail_time_next  = '0;
          if (mute_start == 32'd0) begin
            mute_eff = now;
          end
          mute_start_next = mute_eff;
          rp = coord.touch_hit && !(now - mute_eff < {16'd0, cfg.boot_mute_ms});

          if (rp) begin
            if (press_run == 4'd0) begin
              pr = 4'd1;
            end else if ((abs_diff(coord.nx, run_x) <= cfg.stability_pixels) &&
                         (abs_diff(coord.ny, run_y) <= cfg.stability_pixels)) begin
              pr = sat_inc(press_run);
            end else begin
              pr = 4'd1;
            end
            run_x_next = coord.nx;
            run_y_next = coord.ny;
            mr         = '0;
          end else begin
            mr = sat_inc(miss_run);
            pr = '0;
          end
          press_run_next = pr;
          miss_run_next  = mr;

          if (held) begin
            if (mr >= cfg.release_count) begin
              release_time_next = now;
              held_next         = 1'b0;
            end else begin
              if (rp) begin
                hx = coord.nx;
                hy = coord.ny;
              end
              held_x_next = hx;
              held_y_next = hy;
              res.pressed = 1'b1;
              res.x_pos   = hx;
              res.y_pos   = hy;
            end
          end else if ((pr >= cfg.press_count) &&
                       (now - release_time >= {16'd0, cfg.repress_gap_ms})) begin
            held_next   = 1'b1;
            held_x_next = coord.nx;
            held_y_next = coord.ny;
            res.pressed = 1'b1;
            res.x_pos   = coord.nx;
            res.y_pos   = coord.ny;
          end
        end
      end
    end
  end

  a_recover_clears_count: assert property (@(posedge clk) disable iff (rst)
    go && !online_load && res.recover_request |=> fail_count == 4'd0)
    else $error("recovery did not clear the failure count");

  a_unpressed_zero: assert property (@(posedge clk) disable iff (rst)
    go && !res.pressed |-> (res.x_pos == 9'd0) && (res.y_pos == 9'd0))
    else $error("coordinates nonzero on an unpressed result");

  a_cache_ok: assert property (@(posedge clk) disable iff (rst)
    go && res.from_cache |-> (res.result_status == ST_OK) && !res.recover_request)
    else $error("cached answer with a failure status");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !go |=> $stable(held) && $stable(fail_count) && $stable(press_run))
    else $error("qualifier state moved without a beat");

endmodule

`default_nettype wire

// File: sv/touch_press_qualifier_top.sv
// Touch press qualifier top: input register, decode and qualify logic,
// result register, configuration registers. Depends on tpq_pkg, tpq_coord, tpq_qualify.
// A beat is held in the input register, then its result in the result register.
// Throughput: one beat per cycle; the input register advances whenever the
// result register is empty or being taken. Synchronous reset clears both
// registers' valid bits and loads the register defaults and the qualifier state.
`default_nettype none

module touch_press_qualifier_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tpq_pkg::tpq_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tpq_pkg::tpq_out_t                   out_data,
  input  logic                                cfg_write,
  input  logic [tpq_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tpq_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tpq_pkg::*;

  logic       beat_valid;
  tpq_in_t    beat;
  tpq_cfg_t   cfg;
  tpq_cfg_t   cfg_eff;
  tpq_coord_t coord;
  tpq_out_t   res;
  logic       advance;
  logic       go;
  logic       online_load;

  assign advance     = !out_valid || !out_stall;
  assign in_stall    = beat_valid && !advance;
  assign go          = beat_valid && advance;
  assign online_load = cfg_write && (cfg_index == REG_START_ONLINE);

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (!in_stall) begin
      beat_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      beat <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= beat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_count      <= 4'd2;
      cfg.release_count    <= 4'd1;
      cfg.stability_pixels <= 9'd150;
      cfg.repress_gap_ms   <= 16'd150;
      cfg.boot_mute_ms     <= 16'd1500;
      cfg.fail_limit       <= 4'd8;
      cfg.start_online     <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PRESS_COUNT:      cfg.press_count      <= cfg_data[3:0];
        REG_RELEASE_COUNT:    cfg.release_count    <= cfg_data[3:0];
        REG_STABILITY_PIXELS: cfg.stability_pixels <= cfg_data[8:0];
        REG_REPRESS_GAP_MS:   cfg.repress_gap_ms   <= cfg_data;
        REG_BOOT_MUTE_MS:     cfg.boot_mute_ms     <= cfg_data;
        REG_FAIL_LIMIT:       cfg.fail_limit       <= cfg_data[3:0];
        REG_START_ONLINE:     cfg.start_online     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_eff = cfg;
    if (online_load) begin
      cfg_eff.start_online = cfg_data[0];
    end
  end

  tpq_coord u_coord (
    .beat  (beat),
    .coord (coord)
  );

  tpq_qualify u_qualify (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .beat        (beat),
    .coord       (coord),
    .cfg         (cfg_eff),
    .online_load (online_load),
    .res         (res)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for touch_press_qualifier_top: directed and random poll streams
// with random idling on both channels, checked beat by beat against an
// in-bench predictor. Depends on tpq_pkg and the block's RTL.

module tb_top;
  import tpq_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_POLLS   = 235;

  class press_tracker;
    logic [3:0]  press_db, release_db, fail_lim;
    logic [8:0]  stab_px;
    logic [15:0] gap_ms, mute_ms;
    logic        start_on;
    logic        online, held;
    logic [31:0] reprobe_time, fail_time, sample_time, release_time;
    logic [31:0] cam_start, recover_time, mute_start;
    logic [8:0]  held_x, held_y, run_x, run_y;
    logic [3:0]  fail_count, press_run, miss_run;
    tpq_out_t    expected_reports[$];
    int          errors;

    function new();
      press_db = 4'd2;
      release_db = 4'd1;
      stab_px = 9'd150;
      gap_ms = 16'd150;
      mute_ms = 16'd1500;
      fail_lim = 4'd8;
      start_on = 1'b1;
      online = 1'b1;
      held = 1'b0;
      reprobe_time = '0;
      fail_time = '0;
      sample_time = '0;
      release_time = '0;
      cam_start = '0;
      recover_time = '0;
      mute_start = '0;
      held_x = '0;
      held_y = '0;
      run_x = '0;
      run_y = '0;
      fail_count = '0;
      press_run = '0;
      miss_run = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      unique case (idx)
        REG_PRESS_COUNT:      press_db = val[3:0];
        REG_RELEASE_COUNT:    release_db = val[3:0];
        REG_STABILITY_PIXELS: stab_px = val[8:0];
        REG_REPRESS_GAP_MS:   gap_ms = val;
        REG_BOOT_MUTE_MS:     mute_ms = val;
        REG_FAIL_LIMIT:       fail_lim = val[3:0];
        REG_START_ONLINE: begin
          start_on = val[0];
          online = val[0];
        end
        default: ;
      endcase
    endfunction

    function logic [3:0] bump(logic [3:0] v);
      return (v < COUNT_MAX) ? v + 4'd1 : COUNT_MAX;
    endfunction

    function logic [8:0] span(logic [8:0] a, logic [8:0] b);
      return (a >= b) ? a - b : b - a;
    endfunction

    function tpq_out_t report(logic pr, logic [8:0] x, logic [8:0] y, logic [1:0] st,
                              logic rec, logic cache);
      tpq_out_t r;
      r.pressed = pr;
      r.x_pos = pr ? x : 9'd0;
      r.y_pos = pr ? y : 9'd0;
      r.result_status = st;
      r.recover_request = rec;
      r.from_cache = cache;
      return r;
    endfunction

    function tpq_out_t qualify(tpq_in_t p);
      logic [31:0] now;
      logic [11:0] raw_x, raw_y;
      logic [8:0]  nx, ny;
      logic        touch, rep;
      now = p.time_ms;
      raw_x = {p.x_high[3:0], p.x_low};
      raw_y = {p.y_high[3:0], p.y_low};
      nx = '0;
      ny = '0;
      if (!online) begin
        if (now - reprobe_time >= REPROBE_MS) begin
          reprobe_time = now;
          if (p.probe_ack) online = 1'b1;
        end
        return report(1'b0, 9'd0, 9'd0, ST_OFFLINE, 1'b0, 1'b0);
      end
      if (fail_time != 0 && now - fail_time < BACKOFF_MS)
        return report(1'b0, 9'd0, 9'd0, ST_FAIL, 1'b0, 1'b0);
      if (now - sample_time < (held ? CACHE_HELD_MS : CACHE_IDLE_MS))
        return report(held, held_x, held_y, ST_OK, 1'b0, 1'b1);
      if (p.camera_busy) begin
        if (cam_start == 0) cam_start = (now != 0) ? now : 32'd1;
        if (now - cam_start < CAMERA_BYPASS_MS)
          return report(held, held_x, held_y, ST_OK, 1'b0, 1'b1);
      end else begin
        cam_start = '0;
      end
      sample_time = now;
      if (!p.read_ok) begin
        fail_time = (now != 0) ? now : 32'd1;
        if (p.read_timeout) return report(1'b0, 9'd0, 9'd0, ST_TIMEOUT, 1'b0, 1'b0);
        if (p.servo_busy) return report(1'b0, 9'd0, 9'd0, ST_FAIL, 1'b0, 1'b0);
        fail_count = bump(fail_count);
        rep = 1'b0;
        if (fail_count >= fail_lim && now - recover_time > RECOVER_COOL_MS) begin
          rep = 1'b1;
          recover_time = now;
          fail_count = '0;
          online = p.probe_ack;
          mute_start = '0;
        end
        return report(1'b0, 9'd0, 9'd0, ST_FAIL, rep, 1'b0);
      end
      fail_count = '0;
      fail_time = '0;
      touch = (p.status_byte[3:0] == 4'd1) || (p.status_byte[3:0] == 4'd2);
      if (touch) begin
        nx = (raw_y > SCREEN_W) ? SCREEN_W : raw_y[8:0];
        ny = (raw_x > SCREEN_H) ? SCREEN_H : 9'(SCREEN_H - raw_x);
        if (nx == 0 && ny == 0) touch = 1'b0;
      end
      if (mute_start == 0) mute_start = now;
      if (now - mute_start < {16'd0, mute_ms}) touch = 1'b0;
      if (touch) begin
        if (press_run == 0) press_run = 4'd1;
        else if (span(nx, run_x) <= stab_px && span(ny, run_y) <= stab_px)
          press_run = bump(press_run);
        else press_run = 4'd1;
        run_x = nx;
        run_y = ny;
        miss_run = '0;
      end else begin
        miss_run = bump(miss_run);
        press_run = '0;
      end
      if (held) begin
        if (miss_run >= release_db) begin
          release_time = now;
          held = 1'b0;
          return report(1'b0, 9'd0, 9'd0, ST_OK, 1'b0, 1'b0);
        end
        if (touch) begin
          held_x = nx;
          held_y = ny;
        end
        return report(1'b1, held_x, held_y, ST_OK, 1'b0, 1'b0);
      end
      if (press_run >= press_db && now - release_time >= {16'd0, gap_ms}) begin
        held = 1'b1;
        held_x = nx;
        held_y = ny;
        return report(1'b1, nx, ny, ST_OK, 1'b0, 1'b0);
      end
      return report(1'b0, 9'd0, 9'd0, ST_OK, 1'b0, 1'b0);
    endfunction

    function void note_poll(tpq_in_t p);
      expected_reports.push_back(qualify(p));
    endfunction

    function void check_report(tpq_out_t got);
      tpq_out_t e;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected beat %h, expected none", $time, got);
        errors++;
        return;
      end
      e = expected_reports.pop_front();
      if (got !== e) begin
        $display("%0t: result expected %h got %h", $time, e, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic                   clk, rst;
  logic                   in_valid, in_stall, out_valid, out_stall;
  tpq_in_t                in_data;
  tpq_out_t               out_data;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  press_tracker board;
  int           send_idle, recv_idle;
  logic         hold_go, hold_done;
  logic [31:0]  now_ms;
  logic [11:0]  fx, fy;
  logic         finger_down;
  int           finger_left, cam_left;

  touch_press_qualifier_top u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic tpq_in_t poll(logic [31:0] t, logic ok, logic to, logic servo,
                                   logic cam, logic ack, logic [3:0] touches,
                                   logic [11:0] rx, logic [11:0] ry);
    tpq_in_t p;
    p.time_ms = t;
    p.read_ok = ok;
    p.read_timeout = to;
    p.servo_busy = servo;
    p.camera_busy = cam;
    p.probe_ack = ack;
    p.status_byte[7:4] = 4'($urandom_range(0, 15));
    p.status_byte[3:0] = touches;
    p.x_high[7:4] = 4'($urandom_range(0, 15));
    p.x_high[3:0] = rx[11:8];
    p.x_low = rx[7:0];
    p.y_high[7:4] = 4'($urandom_range(0, 15));
    p.y_high[3:0] = ry[11:8];
    p.y_low = ry[7:0];
    return p;
  endfunction

  function automatic tpq_in_t next_poll();
    int         r;
    logic [3:0] touches;
    logic       cam;
    r = $urandom_range(0, 99);
    if (cam_left > 0) now_ms += $urandom_range(1, 1500);
    else if (r < 65) now_ms += $urandom_range(10, 25);
    else if (r < 82) now_ms += $urandom_range(0, 14);
    else if (r < 94) now_ms += $urandom_range(26, 400);
    else if (r < 98) now_ms += $urandom_range(1000, 12000);
    else now_ms = $urandom();
    if (finger_left == 0) begin
      finger_down = !finger_down;
      finger_left = $urandom_range(2, 30);
      fx = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095))
                                       : 12'($urandom_range(0, 340));
      fy = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095))
                                       : 12'($urandom_range(0, 500));
    end
    finger_left--;
    if (finger_down) begin
      if ($urandom_range(0, 9) == 0) begin
        fx = 12'($urandom_range(0, 340));
        fy = 12'($urandom_range(0, 500));
      end else begin
        fx = 12'(fx + $urandom_range(0, 30) - 15);
        fy = 12'(fy + $urandom_range(0, 30) - 15);
      end
      touches = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(1, 2))
                                            : 4'($urandom_range(0, 15));
    end else begin
      touches = ($urandom_range(0, 9) < 8) ? 4'd0 : 4'($urandom_range(0, 15));
      fx = 12'($urandom_range(0, 4095));
      fy = 12'($urandom_range(0, 4095));
    end
    if (cam_left == 0 && $urandom_range(0, 99) < 2) cam_left = $urandom_range(3, 12);
    cam = (cam_left > 0) || ($urandom_range(0, 99) < 3);
    if (cam_left > 0) cam_left--;
    return poll(now_ms, $urandom_range(0, 99) < 92, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), cam, $urandom_range(0, 99) < 75, touches, fx, fy);
  endfunction

  task automatic send_poll(input tpq_in_t p);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    board.note_poll(p);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    board.write_reg(idx, val[CFG_DATA_W-1:0]);
  endtask

  task automatic configure(input int pd, input int rd, input int sp, input int gap,
                           input int mute, input int fl, input int on);
    in_valid <= 1'b0;
    put_reg(REG_PRESS_COUNT, pd);
    put_reg(REG_RELEASE_COUNT, rd);
    put_reg(REG_STABILITY_PIXELS, sp);
    put_reg(REG_REPRESS_GAP_MS, gap);
    put_reg(REG_BOOT_MUTE_MS, mute);
    put_reg(REG_FAIL_LIMIT, fl);
    put_reg(REG_START_ONLINE, on);
    put_reg(REG_UNUSED, $urandom_range(0, 65535));
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receive side: check, then pick stall for the next beat
  initial begin
    int hold_left;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) board.check_report(out_data);
      if (hold_go && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle);
      end
    end
  end

  initial begin
    int phase_cfg [6][7];
    phase_cfg = '{
      '{2, 1, 150, 150, 300, 8, 1},
      '{15, 15, 480, 65535, 0, 15, 1},
      '{0, 0, 0, 0, 65535, 0, 0},
      '{1, 3, 20, 40, 100, 3, 1},
      '{4, 2, 60, 0, 0, 1, 1},
      '{3, 1, 480, 200, 50, 15, 1}
    };
    board = new();
    send_idle = 0;
    recv_idle = 0;
    hold_go = 1'b0;
    finger_down = 1'b0;
    finger_left = 0;
    cam_left = 0;
    fx = '0;
    fy = '0;
    now_ms = '0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_PRESS_COUNT;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    configure(1, 1, 480, 0, 20, 1, 1);
    // recovery, backoff, then mute start at time zero
    send_poll(poll(32'd3000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0, 12'd0, 12'd0));
    send_poll(poll(32'd3050, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd1, 12'd10, 12'd4095));
    send_poll(poll(32'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd1, 12'd10, 12'd4095));
    send_poll(poll(32'd5, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd1, 12'd10, 12'd4095));
    send_poll(poll(32'd20, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd1, 12'd10, 12'd4095));
    send_poll(poll(32'd40, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd2, 12'd4095, 12'd0));
    send_poll(poll(32'd45, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd2, 12'd4095, 12'd0));
    // origin point counts as no touch
    send_poll(poll(32'd55, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd1, 12'd320, 12'd0));
    send_poll(poll(32'd70, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd1, 12'd0, 12'd480));
    send_poll(poll(32'd90, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 4'd3, 12'd100, 12'd100));
    // camera skip, then bypass
    send_poll(poll(32'd110, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 4'd1, 12'd100, 12'd100));
    send_poll(poll(32'd5200, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 4'd15, 12'd100, 12'd100));
    send_poll(poll(32'd5300, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0, 12'd0, 12'd0));
    send_poll(poll(32'd5450, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 4'd0, 12'd0, 12'd0));
    send_poll(poll(32'd5600, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 12'd0, 12'd0));
    // offline, reprobe without and with ack
    send_poll(poll(32'd5700, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd1, 12'd100, 12'd200));
    send_poll(poll(32'd10000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd1, 12'd100, 12'd200));
    send_poll(poll(32'd20000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd1, 12'd100, 12'd200));
    send_poll(poll(32'd20100, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd1, 12'd100, 12'd200));
    send_poll(poll(32'd20130, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd1, 12'd100, 12'd200));
    // failure and camera skip at time zero
    send_poll(poll(32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0, 12'd0, 12'd0));
    send_poll(poll(32'd50, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd1, 12'd100, 12'd200));
    send_poll(poll(32'd200, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0, 12'd0, 12'd0));
    send_poll(poll(32'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 4'd0, 12'd0, 12'd0));
    send_poll(poll(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd1, 12'd4095, 12'd4095));

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      configure(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2], phase_cfg[ph][3],
                phase_cfg[ph][4], phase_cfg[ph][5], phase_cfg[ph][6]);
      send_idle = (ph < 2) ? 37 : (ph < 4) ? 47 : 0;
      recv_idle = (ph < 2) ? 47 : (ph < 4) ? 37 : 0;
      now_ms = (ph == 1) ? 32'hFFFF_E000 : $urandom();
      if (ph == 4) hold_go = 1'b1;
      repeat (PHASE_POLLS) send_poll(next_poll());
    end
    drain();
    if (board.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// File: files.f
sv/tpq_pkg.sv
sv/tpq_coord.sv
sv/tpq_qualify.sv
sv/touch_press_qualifier_top.sv
tb/tb_top.sv
